/* rtl/pcd_pkg.sv */
// Shared types and constants for the PNG chunk deframer.
// Holds the item structs, chunk type codes, status codes and the signature table.
// No dependencies.
`default_nettype none

package pcd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } pcd_in_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        header_seen;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [1:0]  status;
    logic        finished;
  } pcd_out_t;

  // Status codes
  localparam logic [1:0] ST_BUSY       = 2'd0;
  localparam logic [1:0] ST_BAD_SIG    = 2'd1;
  localparam logic [1:0] ST_OK         = 2'd2;
  localparam logic [1:0] ST_SHORT_DATA = 2'd3;

  // Chunk type codes, big-endian ASCII
  localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
  localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
  localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

  localparam int unsigned SIG_LEN        = 8;
  localparam int unsigned FIELD_BYTES    = 4;   // length, type and CRC fields
  localparam int unsigned CHUNK_OVERHEAD = 12;
  localparam int unsigned CRC_BYTES      = CHUNK_OVERHEAD - 2 * FIELD_BYTES;
  localparam int unsigned HDR_DIM_BYTES  = 8;   // width then height in IHDR
  localparam int unsigned MIN_PAYLOAD    = 6;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h89;
      3'd1:    b = 8'h50;
      3'd2:    b = 8'h4E;
      3'd3:    b = 8'h47;
      3'd4:    b = 8'h0D;
      3'd5:    b = 8'h0A;
      3'd6:    b = 8'h1A;
      default: b = 8'h0A;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* rtl/png_chunk_deframer_core.sv */
// PNG chunk deframer: streaming signature check and chunk walker.
// Uses pcd_pkg, pcd_in_reg, pcd_parser and pcd_out_reg.
//
// Input channel in_valid/in_stall/in_data carries one file byte per item,
// with end_of_file set on the last byte. Output channel out_valid/out_stall/
// out_data gives exactly one result item per input item, in order: an IDAT
// byte when payload_valid is set, plus the running header, width, height,
// status and finished fields.
// The item sits in the input register and passes the parser into the result
// register, where it waits until the receiver takes it.
// Throughput is one item per cycle while the receiver does not stall; the
// parse state is a single set of registers updated by short per-byte logic
// (one 32-bit count and compare).
// A result waiting in the result register does not block the input: a new
// item is still taken while the parser stage has room.
// When the receiver stalls, the result is held, the parser stage stops, and
// in_stall rises once the input register holds an item too.
// Synchronous reset empties both registers and returns the parser to the
// signature check with all captured fields cleared.
// After IEND or the end-of-file byte every further byte is consumed and
// answered with the final status and finished held high until reset.
`default_nettype none

module png_chunk_deframer_core
  import pcd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire pcd_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output pcd_out_t      out_data
);

  logic     advance;
  logic     held_valid;
  pcd_in_t  held_data;
  logic     fire;
  pcd_out_t result;

  assign fire = held_valid && advance;

  pcd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .advance    (advance),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  pcd_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (held_data),
    .result (result)
  );

  pcd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (held_valid),
    .res_data  (result),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* rtl/pcd_in_reg.sv */
// Input register of the PNG chunk deframer.
// Holds one accepted item until the parser stage takes it; uses pcd_pkg.
`default_nettype none

module pcd_in_reg
  import pcd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire pcd_in_t in_data,
  input  wire logic    advance,
  output logic         held_valid,
  output pcd_in_t      held_data
);

  // Busy only while a held item cannot move on
  assign in_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
    if (!in_stall) begin
      held_data <= in_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/pcd_parser.sv */
// Chunk walker state and per-byte step logic of the PNG chunk deframer.
// Updates the parse state on each fired item and presents its result; uses pcd_pkg.
`default_nettype none

module pcd_parser
  import pcd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    fire,
  input  wire pcd_in_t item,
  output pcd_out_t     result
);

  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_TYPE = 3'd2,
    PH_DATA = 3'd3,
    PH_CRC  = 3'd4,
    PH_BAD  = 3'd5
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  sig_idx, sig_idx_next;
  logic [31:0] field_cnt, field_cnt_next;
  logic [31:0] field_cnt_inc;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] chunk_type, chunk_type_next;
  logic [31:0] width_store, width_store_next;
  logic [31:0] height_store, height_store_next;
  logic        header_flag, header_flag_next;
  logic [2:0]  payload_count, payload_count_next;
  logic        done_flag, done_flag_next;
  logic [7:0]  pay_byte;
  logic        pay_valid;
  logic [1:0]  status;

  assign field_cnt_inc = field_cnt + 32'd1;

  always_comb begin
    phase_next         = phase;
    sig_idx_next       = sig_idx;
    field_cnt_next     = field_cnt;
    chunk_length_next  = chunk_length;
    chunk_type_next    = chunk_type;
    width_store_next   = width_store;
    height_store_next  = height_store;
    header_flag_next   = header_flag;
    payload_count_next = payload_count;
    done_flag_next     = done_flag;
    pay_byte           = 8'd0;
    pay_valid          = 1'b0;

    if (!done_flag) begin
      unique case (phase)
        PH_SIG: begin
          if (item.data_byte == sig_byte(sig_idx[2:0])) begin
            sig_idx_next = sig_idx + 4'd1;
            if (sig_idx_next >= 4'(SIG_LEN)) begin
              phase_next     = PH_LEN;
              field_cnt_next = 32'd0;
            end
          end else begin
            phase_next = PH_BAD;
          end
        end
        PH_LEN: begin
          chunk_length_next = {chunk_length[23:0], item.data_byte};
          field_cnt_next    = field_cnt_inc;
          if (field_cnt_inc >= 32'(FIELD_BYTES)) begin
            phase_next     = PH_TYPE;
            field_cnt_next = 32'd0;
          end
        end
        PH_TYPE: begin
          chunk_type_next = {chunk_type[23:0], item.data_byte};
          field_cnt_next  = field_cnt_inc;
          if (field_cnt_inc >= 32'(FIELD_BYTES)) begin
            field_cnt_next = 32'd0;
            if (chunk_type_next == TYPE_IEND) begin
              done_flag_next = 1'b1;
            end else if (chunk_length == 32'd0) begin
              phase_next = PH_CRC;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          if (chunk_type == TYPE_IHDR) begin
            if (field_cnt < 32'(FIELD_BYTES)) begin
              width_store_next = {width_store[23:0], item.data_byte};
            end else if (field_cnt < 32'(HDR_DIM_BYTES)) begin
              height_store_next = {height_store[23:0], item.data_byte};
            end
            if (field_cnt == 32'(HDR_DIM_BYTES - 1)) begin
              header_flag_next = 1'b1;
            end
          end else if (chunk_type == TYPE_IDAT) begin
            pay_byte  = item.data_byte;
            pay_valid = 1'b1;
            if (payload_count < 3'(MIN_PAYLOAD)) begin
              payload_count_next = payload_count + 3'd1;
            end
          end
          field_cnt_next = field_cnt_inc;
          if (field_cnt_inc >= chunk_length) begin
            phase_next     = PH_CRC;
            field_cnt_next = 32'd0;
          end
        end
        PH_CRC: begin
          // skip the CRC, no check
          field_cnt_next = field_cnt_inc;
          if (field_cnt_inc >= 32'(CRC_BYTES)) begin
            phase_next        = PH_LEN;
            field_cnt_next    = 32'd0;
            chunk_length_next = 32'd0;
          end
        end
        default: begin
        end
      endcase

      if (item.end_of_file) begin
        if (phase_next == PH_SIG) begin
          phase_next = PH_BAD;
        end
        done_flag_next = 1'b1;
      end
    end

    if (!done_flag_next) begin
      status = ST_BUSY;
    end else if (phase_next == PH_BAD) begin
      status = ST_BAD_SIG;
    end else if (payload_count_next >= 3'(MIN_PAYLOAD)) begin
      status = ST_OK;
    end else begin
      status = ST_SHORT_DATA;
    end
  end

  always_comb begin
    result.payload_byte  = pay_byte;
    result.payload_valid = pay_valid;
    result.header_seen   = header_flag_next;
    result.image_width   = width_store_next;
    result.image_height  = height_store_next;
    result.status        = status;
    result.finished      = done_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SIG;
      sig_idx       <= 4'd0;
      field_cnt     <= 32'd0;
      chunk_length  <= 32'd0;
      chunk_type    <= 32'd0;
      width_store   <= 32'd0;
      height_store  <= 32'd0;
      header_flag   <= 1'b0;
      payload_count <= 3'd0;
      done_flag     <= 1'b0;
    end else if (fire) begin
      phase         <= phase_next;
      sig_idx       <= sig_idx_next;
      field_cnt     <= field_cnt_next;
      chunk_length  <= chunk_length_next;
      chunk_type    <= chunk_type_next;
      width_store   <= width_store_next;
      height_store  <= height_store_next;
      header_flag   <= header_flag_next;
      payload_count <= payload_count_next;
      done_flag     <= done_flag_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/pcd_out_reg.sv */
// Result register of the PNG chunk deframer.
// Holds each result item until the receiver takes it; uses pcd_pkg.
`default_nettype none

module pcd_out_reg
  import pcd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     res_valid,
  input  wire pcd_out_t res_data,
  output logic          advance,
  output logic          out_valid,
  input  wire logic     out_stall,
  output pcd_out_t      out_data
);

  // Load when empty or when the current item is taken this cycle
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end
    if (advance) begin
      out_data <= res_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/pcd_checker.sv */
// Port-level checker for the PNG chunk deframer, bound to the top level.
// Watches the output channel only; uses pcd_pkg.
`default_nettype none

module pcd_checker
  import pcd_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire pcd_out_t out_data
);

  logic seen_finished;
  logic seen_header;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_finished <= 1'b0;
      seen_header   <= 1'b0;
    end else if (out_valid && !out_stall) begin
      seen_finished <= seen_finished || out_data.finished;
      seen_header   <= seen_header || out_data.header_seen;
    end
  end

  a_status_matches_finished: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.finished == (out_data.status != ST_BUSY)))
    else $error("status and finished disagree");

  a_finished_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && seen_finished) |-> out_data.finished)
    else $error("finished dropped after parsing ended");

  a_header_sticky: assert property (@(posedge clk) disable iff (rst)
    (out_valid && seen_header) |-> out_data.header_seen)
    else $error("header_seen dropped");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output item changed");

endmodule

bind png_chunk_deframer_core pcd_checker u_pcd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

/* tb/tb_png_chunk_deframer_core.sv */
// Self-checking testbench for png_chunk_deframer_core: streams one PNG file byte by byte.
// A behavioural parser predicts every result item; the RTL's output items are checked against it.
// Depends on pcd_pkg and png_chunk_deframer_core.
`timescale 1ns / 1ps

module tb_png_chunk_deframer_core;
  import pcd_pkg::*;

  typedef enum logic [2:0] {
    PH_SIG, PH_LEN, PH_TYPE, PH_DATA, PH_CRC, PH_BAD
  } parse_ph_t;

  localparam logic [7:0] PNG_SIG [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
                                         8'h0D, 8'h0A, 8'h1A, 8'h0A};
  localparam int FILE_BYTES  = 1150;
  localparam int IDLE_PCT [4] = '{0, 73, 0, 19};
  localparam int STALL_PCT [4] = '{0, 0, 73, 19};
  localparam int HOLD_AT     = 8;
  localparam int HOLD_LEN    = 48;
  localparam int STUCK_LIMIT = 4000;
  localparam int MAX_REPORTS = 20;

  logic     clk;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  pcd_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  pcd_out_t out_data;

  png_chunk_deframer_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  pcd_in_t  file_q [$];
  pcd_in_t  pend_q [$];
  pcd_out_t parse_q [$];

  int idle_pct = 0;
  int stall_pct = 0;
  int err_cnt = 0;
  int rcv_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit in_fire = 1'b0;
  int stuck_cyc = 0;

  // Parser state of the prediction
  parse_ph_t   ph = PH_SIG;
  int          sig_idx = 0;
  logic [31:0] fcnt = '0;
  logic [31:0] clen = '0;
  logic [31:0] ctype = '0;
  logic [31:0] wid = '0;
  logic [31:0] hgt = '0;
  logic        hdr = 1'b0;
  int          pay_cnt = 0;
  logic        fin = 1'b0;

  function automatic pcd_out_t parse_byte(input pcd_in_t it);
    pcd_out_t   r;
    logic [7:0] b;
    b = it.data_byte;
    r = '0;
    if (!fin) begin
      case (ph)
        PH_SIG: begin
          if (b == PNG_SIG[sig_idx]) begin
            sig_idx++;
            if (sig_idx >= SIG_LEN) begin
              ph = PH_LEN;
              fcnt = '0;
            end
          end else begin
            ph = PH_BAD;
          end
        end
        PH_LEN: begin
          clen = {clen[23:0], b};
          fcnt++;
          if (fcnt >= FIELD_BYTES) begin
            ph = PH_TYPE;
            fcnt = '0;
          end
        end
        PH_TYPE: begin
          ctype = {ctype[23:0], b};
          fcnt++;
          if (fcnt >= FIELD_BYTES) begin
            fcnt = '0;
            if (ctype == TYPE_IEND) fin = 1'b1;
            else if (clen == 0) ph = PH_CRC;
            else ph = PH_DATA;
          end
        end
        PH_DATA: begin
          if (ctype == TYPE_IHDR) begin
            if (fcnt < 4) wid = {wid[23:0], b};
            else if (fcnt < HDR_DIM_BYTES) hgt = {hgt[23:0], b};
            if (fcnt == HDR_DIM_BYTES - 1) hdr = 1'b1;
          end else if (ctype == TYPE_IDAT) begin
            r.payload_byte  = b;
            r.payload_valid = 1'b1;
            if (pay_cnt < MIN_PAYLOAD) pay_cnt++;
          end
          fcnt++;
          if (fcnt >= clen) begin
            ph = PH_CRC;
            fcnt = '0;
          end
        end
        PH_CRC: begin
          fcnt++;
          if (fcnt >= CRC_BYTES) begin
            ph = PH_LEN;
            fcnt = '0;
            clen = '0;
          end
        end
        default: ;
      endcase
      if (it.end_of_file) begin
        // an end inside the signature counts as a bad signature
        if (ph == PH_SIG) ph = PH_BAD;
        fin = 1'b1;
      end
    end
    r.status = ST_BUSY;
    if (fin) begin
      if (ph == PH_BAD) r.status = ST_BAD_SIG;
      else if (pay_cnt >= MIN_PAYLOAD) r.status = ST_OK;
      else r.status = ST_SHORT_DATA;
    end
    r.header_seen  = hdr;
    r.image_width  = wid;
    r.image_height = hgt;
    r.finished     = fin;
    return r;
  endfunction

  // ---------------- file construction ----------------
  task automatic put_byte(input logic [7:0] b, input logic eof);
    pcd_in_t it;
    it.data_byte   = b;
    it.end_of_file = eof;
    file_q.push_back(it);
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) put_byte(w[8*i +: 8], 1'b0);
  endtask

  // First eight data bytes come from head, the rest are random
  task automatic put_chunk(input logic [31:0] t, input int unsigned len,
                           input logic [63:0] head);
    put_word(len);
    put_word(t);
    for (int i = 0; i < len; i++) begin
      if (i < 8) put_byte(head[63 - 8*i -: 8], 1'b0);
      else put_byte(8'($urandom_range(0, 255)), 1'b0);
    end
    put_word($urandom);
  endtask

  // Bytes the block must ignore once it has finished
  task automatic put_tail(input int n);
    for (int i = 0; i < n; i++)
      put_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  function automatic logic [31:0] pick_dim();
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_chunk(input bit allow_idat);
    int unsigned len;
    int          r;
    logic [31:0] t;
    r   = $urandom_range(0, 99);
    len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 80) : $urandom_range(0, 12);
    if (r < 50 && allow_idat) begin
      put_chunk(TYPE_IDAT, len, {$urandom, $urandom});
    end else if (r < 65) begin
      len = ($urandom_range(0, 3) != 0) ? 13 : $urandom_range(0, 12);
      put_chunk(TYPE_IHDR, len, {pick_dim(), pick_dim()});
    end else begin
      do t = $urandom; while (t == TYPE_IEND || t == TYPE_IDAT);
      put_chunk(t, len, {$urandom, $urandom});
    end
  endtask

  // ---------------- sender ----------------
  always @(negedge clk) begin : send_proc
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pend_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_data  <= pend_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- receiver ----------------
  always @(negedge clk) begin : recv_proc
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && rcv_cnt >= HOLD_AT) begin
      // long hold-off: let the block fill up and push back on its input
      out_stall <= 1'b1;
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------- monitor and checker ----------------
  task automatic cmp_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (a !== e) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("%0t %s mismatch: expected %0h, got %0h", $time, name, e, a);
    end
  endtask

  always @(posedge clk) begin : mon_proc
    pcd_out_t e;
    in_fire <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (in_valid && !in_stall) parse_q.push_back(parse_byte(in_data));
      if (out_valid && !out_stall) begin
        rcv_cnt <= rcv_cnt + 1;
        if (parse_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t unexpected item: expected none, got %h", $time, out_data);
        end else begin
          e = parse_q.pop_front();
          cmp_field("payload_byte", e.payload_byte, out_data.payload_byte);
          cmp_field("payload_valid", e.payload_valid, out_data.payload_valid);
          cmp_field("header_seen", e.header_seen, out_data.header_seen);
          cmp_field("image_width", e.image_width, out_data.image_width);
          cmp_field("image_height", e.image_height, out_data.image_height);
          cmp_field("status", e.status, out_data.status);
          cmp_field("finished", e.finished, out_data.finished);
        end
      end
    end
  end

  // Ends the run when nothing moves for too long
  always @(posedge clk) begin : stuck_proc
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cyc <= 0;
    end else if (stuck_cyc >= STUCK_LIMIT) begin
      $display("[png_chunk_deframer_core] ERROR");
      $finish;
    end else begin
      stuck_cyc <= stuck_cyc + 1;
    end
  end

  // ---------------- stimulus ----------------
  initial begin : stim_proc
    int         mode;
    int         k;
    int         s0;
    int         cut;
    int         n;
    logic [7:0] b;
    pcd_in_t    last;
    bit         allow;

    // mode 0: bad signature, 1: too little image data, 2..5: truncated, 6..9: IEND
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      if ($urandom_range(0, 1) == 1) begin
        k = $urandom_range(0, 7);
        for (int i = 0; i < k; i++) put_byte(PNG_SIG[i], 1'b0);
        do b = 8'($urandom_range(0, 255)); while (b == PNG_SIG[k]);
        put_byte(b, 1'b0);
        while (file_q.size() < FILE_BYTES) put_byte(8'($urandom_range(0, 255)), 1'b0);
        put_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        // file ends before the signature is complete
        k = $urandom_range(0, 6);
        for (int i = 0; i < k; i++) put_byte(PNG_SIG[i], 1'b0);
        put_byte(PNG_SIG[k], 1'b1);
      end
      put_tail(FILE_BYTES + 60 - file_q.size());
    end else begin
      for (int i = 0; i < SIG_LEN; i++) put_byte(PNG_SIG[i], 1'b0);
      if (mode == 1 && $urandom_range(0, 1) == 1) begin
        // end of file on the last signature byte
        last = file_q.pop_back();
        last.end_of_file = 1'b1;
        file_q.push_back(last);
        put_tail(FILE_BYTES - file_q.size());
      end else begin
        put_chunk(TYPE_IHDR, HDR_DIM_BYTES, {32'hFFFF_FFFF, 32'h0000_0000});
        allow = (mode != 1);
        if (!allow) put_chunk(TYPE_IDAT, $urandom_range(0, MIN_PAYLOAD - 1), {$urandom, $urandom});
        while (file_q.size() < FILE_BYTES) add_chunk(allow);
        if (mode >= 6 || (mode == 1 && $urandom_range(0, 1) == 1)) begin
          put_word($urandom_range(0, 3));
          put_word(TYPE_IEND);
          put_tail($urandom_range(1, 8));
        end else begin
          // cut the last chunk short at any byte
          s0 = file_q.size();
          add_chunk(allow);
          cut = $urandom_range(s0, file_q.size() - 1);
          while (file_q.size() > cut + 1) void'(file_q.pop_back());
          last = file_q.pop_back();
          last.end_of_file = 1'b1;
          file_q.push_back(last);
          put_tail($urandom_range(0, 4));
        end
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    n = file_q.size();
    for (int p = 0; p < 4; p++) begin
      idle_pct  = IDLE_PCT[p];
      stall_pct = STALL_PCT[p];
      for (int i = p * n / 4; i < (p + 1) * n / 4; i++) pend_q.push_back(file_q[i]);
      // hold the sender until every result of this part has come back
      while (pend_q.size() != 0 || in_valid || parse_q.size() != 0) @(posedge clk);
    end

    repeat (8) @(posedge clk);
    if (err_cnt == 0 && parse_q.size() == 0) begin
      $display("[png_chunk_deframer_core] OK");
    end else begin
      $display("[png_chunk_deframer_core] ERROR");
    end
    $finish;
  end

endmodule
